/* hdl/sdcf_pkg.sv */
package sdcf_pkg;

    // Display memory size in bytes; sets the clear length and the cursor wrap
    localparam int DISPLAY_BYTES = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Byte index within one descriptor (init is the longest: DISPLAY_BYTES + 4)
    localparam int IDX_W = $clog2(DISPLAY_BYTES + 4);

    localparam int CUR_W = 4;

    // Operation codes
    localparam logic [2:0] OP_INIT       = 3'd0;
    localparam logic [2:0] OP_CLEAR      = 3'd1;
    localparam logic [2:0] OP_SET_LED    = 3'd2;
    localparam logic [2:0] OP_RAW_WRITE  = 3'd3;
    localparam logic [2:0] OP_WRITE_CHAR = 3'd4;
    localparam logic [2:0] OP_STRING     = 3'd5;
    localparam logic [2:0] OP_BRIGHTNESS = 3'd6;

    // Chip command bytes
    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_DISPLAY    = 8'h80;
    localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
    localparam logic [7:0] CMD_FULL_ON    = 8'h8F;
    localparam logic [7:0] SEG_DOT        = 8'h80;
    localparam logic [7:0] SEG_DASH       = 8'h40;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_DASH      = 8'h2D;

    localparam logic [7:0] SEG_TABLE [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    // Kind of byte sequence the back end produces
    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,   // one byte framed alone
        KIND_PAIRS  = 2'd1,   // one or two command/data frames
        KIND_CLEAR  = 2'd2,   // address frame with zero fill, then address alone
        KIND_INIT   = 2'd3    // mode and display commands, then clear
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic            two_pairs;
        logic [3:0][7:0] bytes;
    } desc_t;

    // Map a character code to its segment pattern
    function automatic logic [7:0] glyph_of(input logic [7:0] c);
        logic [7:0] g;
        begin
            g = 8'h00;
            if (c inside {[8'h30:8'h39]}) begin
                g = SEG_TABLE[4'(c - 8'h30)];
            end else if (c inside {[8'h61:8'h66]}) begin
                g = SEG_TABLE[4'(c - 8'h57)];
            end else if (c inside {[8'h41:8'h46]}) begin
                g = SEG_TABLE[4'(c - 8'h37)];
            end else if (c == CHAR_DASH) begin
                g = SEG_DASH;
            end
            return g;
        end
    endfunction

    // Advance the cursor by 2, wrapping at the display size
    function automatic logic [CUR_W-1:0] cursor_adv(input logic [CUR_W-1:0] c);
        logic [CUR_W:0] sum;
        begin
            sum = {1'b0, c} + (CUR_W+1)'(2);
            if (sum >= (CUR_W+1)'(DISPLAY_BYTES)) begin
                sum = sum - (CUR_W+1)'(DISPLAY_BYTES);
            end
            return sum[CUR_W-1:0];
        end
    endfunction

endpackage

/* hdl/segment_display_command_framer_unit.sv */
// Channel  | Dir | Data                                      | Side band
// ---------+-----+-------------------------------------------+-----------------------------------
// s_ (ops) | in  | operation[2:0] position[6:3] value[14:7]  | tuser first_of_string, tlast last
// m_ (cmd) | out | frame_byte[7:0]                           | tuser start[0] end[1], tlast last
//
// Each request expands to its command bytes, one byte per cycle unless m_ stalls: 1 for brightness,
// 2 or 4 for writes, DISPLAY_BYTES+2 for clear, DISPLAY_BYTES+4 for init (20 bytes).
// The back-end byte sequencer sets the rate; the front accepts one request per cycle
// while the four-entry queue has room, and a request that makes no bytes uses no slot.
// Reset is synchronous and active low; it clears the cursor, held glyph and queue.
// A stall on m_ holds the output register and fills the queue before s_tready drops.
module segment_display_command_framer_unit
    import sdcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[2:0], position[6:3], value[14:7], zero[15]
    input  logic        s_tuser,   // first_of_string[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte[7:0]
    output logic [1:0]  m_tuser,   // frame_start[0], frame_end[1]
    output logic        m_tlast
);

    logic  q_push, q_pop, q_full, q_empty;
    desc_t push_desc, head_desc;
    logic  frame_start, frame_end;

    assign s_tready = !q_full;

    sdcf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .operation       (s_tdata[2:0]),
        .position        (s_tdata[6:3]),
        .value           (s_tdata[14:7]),
        .first_of_string (s_tuser),
        .last_of_string  (s_tlast),
        .push            (q_push),
        .desc            (push_desc)
    );

    sdcf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    sdcf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_desc   (head_desc),
        .empty       (q_empty),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .frame_byte  (m_tdata),
        .frame_start (frame_start),
        .frame_end   (frame_end),
        .last        (m_tlast)
    );

    assign m_tuser = {frame_end, frame_start};

    // Never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("push into full queue");

    // Retiring a descriptor always presents its final byte next
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |=> m_tvalid && m_tlast)
        else $error("descriptor retired without final byte");

    // Pending work with a free output register is always picked up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_empty && !m_tvalid) |=> m_tvalid)
        else $error("back end idle with queued work");

    // A final byte always closes a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> frame_end)
        else $error("final byte leaves strobe low");

endmodule

/* hdl/sdcf_front.sv */
module sdcf_front
    import sdcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [3:0]  position,
    input  logic [7:0]  value,
    input  logic        first_of_string,
    input  logic        last_of_string,
    output logic        push,
    output desc_t       desc
);

    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [7:0]       held_glyph_reg, held_glyph_next;
    logic             glyph_held_reg, glyph_held_next;

    // Classify the request and work out the string state
    always_comb begin
        logic [CUR_W-1:0] c;
        logic [7:0]       g;
        logic             h;
        logic [1:0]       np;
        c  = cursor_reg;
        g  = held_glyph_reg;
        h  = glyph_held_reg;
        np = 2'd0;
        desc.kind      = KIND_SINGLE;
        desc.two_pairs = 1'b0;
        desc.bytes     = '0;
        push           = 1'b0;

        case (operation)
            OP_INIT: begin
                c    = '0;
                g    = 8'h00;
                h    = 1'b0;
                desc.kind = KIND_INIT;
                push = 1'b1;
            end
            OP_CLEAR: begin
                desc.kind = KIND_CLEAR;
                push = 1'b1;
            end
            OP_SET_LED: begin
                desc.kind     = KIND_PAIRS;
                desc.bytes[0] = {CMD_ADDRESS[7:4], position[2:0], 1'b1};
                desc.bytes[1] = value;
                push = 1'b1;
            end
            OP_RAW_WRITE: begin
                desc.kind     = KIND_PAIRS;
                desc.bytes[0] = {CMD_ADDRESS[7:4], position};
                desc.bytes[1] = value;
                push = 1'b1;
            end
            OP_WRITE_CHAR: begin
                desc.kind     = KIND_PAIRS;
                desc.bytes[0] = {CMD_ADDRESS[7:4], c};
                desc.bytes[1] = glyph_of(value);
                c    = cursor_adv(c);
                push = 1'b1;
            end
            OP_STRING: begin
                desc.kind = KIND_PAIRS;
                // Drop any glyph left from an unfinished string
                if (first_of_string) begin
                    c = '0;
                    g = 8'h00;
                    h = 1'b0;
                end
                if (value == CHAR_DOT && h) begin
                    desc.bytes[0] = {CMD_ADDRESS[7:4], c};
                    desc.bytes[1] = g | SEG_DOT;
                    np = 2'd1;
                    c  = cursor_adv(c);
                    g  = 8'h00;
                    h  = 1'b0;
                end else begin
                    if (h) begin
                        desc.bytes[0] = {CMD_ADDRESS[7:4], c};
                        desc.bytes[1] = g;
                        np = 2'd1;
                        c  = cursor_adv(c);
                    end
                    g = glyph_of(value);
                    h = 1'b1;
                end
                // Flush the held glyph at the end of the string
                if (last_of_string && h) begin
                    if (np != 2'd0) begin
                        desc.bytes[2] = {CMD_ADDRESS[7:4], c};
                        desc.bytes[3] = g;
                    end else begin
                        desc.bytes[0] = {CMD_ADDRESS[7:4], c};
                        desc.bytes[1] = g;
                    end
                    np = np + 2'd1;
                    c  = cursor_adv(c);
                    g  = 8'h00;
                    h  = 1'b0;
                end
                desc.two_pairs = (np == 2'd2);
                push = (np != 2'd0);
            end
            OP_BRIGHTNESS: begin
                desc.kind     = KIND_SINGLE;
                desc.bytes[0] = CMD_DISPLAY | {4'h0, value[3:0]};
                push = 1'b1;
            end
            default: begin
                push = 1'b0;
            end
        endcase

        push            = push && in_valid && in_ready;
        cursor_next     = c;
        held_glyph_next = g;
        glyph_held_next = h;
    end

    // Update string state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg     <= '0;
            held_glyph_reg <= 8'h00;
            glyph_held_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            cursor_reg     <= cursor_next;
            held_glyph_reg <= held_glyph_next;
            glyph_held_reg <= glyph_held_next;
        end
    end

endmodule

/* hdl/sdcf_queue.sv */
module sdcf_queue
    import sdcf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head_desc,
    output logic  full,
    output logic  empty
);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = entry_reg[rptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wptr_next  = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

/* hdl/sdcf_back.sv */
module sdcf_back
    import sdcf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  desc_t      head_desc,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_start,
    output logic       frame_end,
    output logic       last
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             start_reg, end_reg, last_reg;

    logic [7:0]       step_byte;
    logic             step_start, step_end, step_last;
    logic [IDX_W-1:0] last_idx;
    logic             load;

    // Work out the byte at the current index of the head descriptor
    always_comb begin
        logic [IDX_W-1:0] j;
        j          = idx_reg;
        step_byte  = 8'h00;
        step_start = 1'b0;
        step_end   = 1'b0;
        last_idx   = '0;
        case (head_desc.kind)
            KIND_SINGLE: begin
                step_byte  = head_desc.bytes[0];
                step_start = 1'b1;
                step_end   = 1'b1;
                last_idx   = '0;
            end
            KIND_PAIRS: begin
                step_byte  = head_desc.bytes[idx_reg[1:0]];
                step_start = !idx_reg[0];
                step_end   = idx_reg[0];
                last_idx   = head_desc.two_pairs ? IDX_W'(3) : IDX_W'(1);
            end
            KIND_CLEAR, KIND_INIT: begin
                if (head_desc.kind == KIND_INIT) begin
                    last_idx = IDX_W'(DISPLAY_BYTES + 3);
                    j        = idx_reg - IDX_W'(2);
                end else begin
                    last_idx = IDX_W'(DISPLAY_BYTES + 1);
                end
                if (head_desc.kind == KIND_INIT && idx_reg < IDX_W'(2)) begin
                    step_byte  = idx_reg[0] ? CMD_FULL_ON : CMD_DATA_WRITE;
                    step_start = 1'b1;
                    step_end   = 1'b1;
                end else if (j == '0) begin
                    step_byte  = CMD_ADDRESS;
                    step_start = 1'b1;
                end else if (j == IDX_W'(DISPLAY_BYTES + 1)) begin
                    step_byte  = CMD_ADDRESS;
                    step_start = 1'b1;
                    step_end   = 1'b1;
                end else begin
                    step_end = (j == IDX_W'(DISPLAY_BYTES));
                end
            end
            default: begin
                last_idx = '0;
            end
        endcase
        step_last = (idx_reg == last_idx);
    end

    // Load the output register when the queue holds work and the register is free or being drained
    assign load = !empty && (!valid_reg || out_ready);
    assign pop  = load && step_last;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = step_last ? '0 : idx_reg + IDX_W'(1);
        end
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg  <= step_byte;
            start_reg <= step_start;
            end_reg   <= step_end;
            last_reg  <= step_last;
        end
    end

    assign out_valid   = valid_reg;
    assign frame_byte  = byte_reg;
    assign frame_start = start_reg;
    assign frame_end   = end_reg;
    assign last        = last_reg;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sdcf_pkg::*;

    localparam logic [2:0] OP_UNDEFINED   = 3'd7;
    localparam int         TAIL_ITEMS     = 15;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 40;

    localparam logic [7:0] HEX_SEGMENTS [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
    };

    typedef struct {
        logic [2:0] op;
        logic [3:0] pos;
        logic [7:0] val;
        logic       first_char;
        logic       final_char;
        bit         drain;
    } op_request_t;

    typedef struct {
        logic [7:0] code;
        logic       opens;
        logic       closes;
        logic       tail;
    } frame_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // operation[2:0], position[6:3], value[14:7], zero[15]
    logic        s_tuser  = 1'b0; // first_of_string[0]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // frame_byte[7:0]
    logic [1:0]  m_tuser;         // frame_start[0], frame_end[1]
    logic        m_tlast;

    op_request_t op_requests[$];
    frame_t      expected_frames[$];

    // Display state as the block should hold it
    logic [3:0] cursor_pos    = '0;
    logic [7:0] held_segments = '0;
    logic       segments_held = 1'b0;

    int  requests_total = 0;
    int  requests_taken = 0;
    int  error_count    = 0;
    int  quiet_cycles   = 0;
    bit  req_taken      = 1'b0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  sender_idling  = 1'b1;
    bit  sink_idling    = 1'b1;

    segment_display_command_framer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Map a character code to its segment pattern
    function automatic logic [7:0] char_segments(input logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39) begin
            return HEX_SEGMENTS[4'(ch - 8'h30)];
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            return HEX_SEGMENTS[4'(ch - 8'h61 + 8'd10)];
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            return HEX_SEGMENTS[4'(ch - 8'h41 + 8'd10)];
        end else if (ch == CHAR_DASH) begin
            return SEG_DASH;
        end
        return 8'h00;
    endfunction

    task automatic emit(input logic [7:0] code, input logic opens, input logic closes);
        frame_t f;
        f.code   = code;
        f.opens  = opens;
        f.closes = closes;
        f.tail   = 1'b0;
        expected_frames.push_back(f);
    endtask

    task automatic write_at_cursor(input logic [7:0] seg);
        emit(CMD_ADDRESS | {4'h0, cursor_pos}, 1'b1, 1'b0);
        emit(seg, 1'b0, 1'b1);
        cursor_pos = 4'((int'(cursor_pos) + 2) % DISPLAY_BYTES);
    endtask

    task automatic clear_frames();
        emit(CMD_ADDRESS, 1'b1, 1'b0);
        for (int i = 0; i < DISPLAY_BYTES; i++) begin
            emit(8'h00, 1'b0, i == DISPLAY_BYTES - 1);
        end
        emit(CMD_ADDRESS, 1'b1, 1'b1);
    endtask

    // Expand one accepted request into the command bytes it must produce
    task automatic frame_operation(input op_request_t r);
        int prior_count;
        prior_count = expected_frames.size();
        case (r.op)
            OP_INIT: begin
                cursor_pos    = '0;
                held_segments = '0;
                segments_held = 1'b0;
                emit(CMD_DATA_WRITE, 1'b1, 1'b1);
                emit(CMD_DISPLAY | 8'h0F, 1'b1, 1'b1);
                clear_frames();
            end
            OP_CLEAR: begin
                clear_frames();
            end
            OP_SET_LED: begin
                emit(CMD_ADDRESS | {4'h0, 4'(2 * int'(r.pos) + 1)}, 1'b1, 1'b0);
                emit(r.val, 1'b0, 1'b1);
            end
            OP_RAW_WRITE: begin
                emit(CMD_ADDRESS | {4'h0, r.pos}, 1'b1, 1'b0);
                emit(r.val, 1'b0, 1'b1);
            end
            OP_WRITE_CHAR: begin
                write_at_cursor(char_segments(r.val));
            end
            OP_STRING: begin
                // drop whatever an unfinished string left behind
                if (r.first_char) begin
                    cursor_pos    = '0;
                    held_segments = '0;
                    segments_held = 1'b0;
                end
                if (r.val == CHAR_DOT && segments_held) begin
                    write_at_cursor(held_segments | SEG_DOT);
                    held_segments = '0;
                    segments_held = 1'b0;
                end else begin
                    if (segments_held) begin
                        write_at_cursor(held_segments);
                    end
                    held_segments = char_segments(r.val);
                    segments_held = 1'b1;
                end
                if (r.final_char && segments_held) begin
                    write_at_cursor(held_segments);
                    held_segments = '0;
                    segments_held = 1'b0;
                end
            end
            OP_BRIGHTNESS: begin
                emit(CMD_DISPLAY | {4'h0, r.val[3:0]}, 1'b1, 1'b1);
            end
            default: begin
            end
        endcase
        if (expected_frames.size() > prior_count) begin
            expected_frames[expected_frames.size() - 1].tail = 1'b1;
        end
    endtask

    task automatic add_request(input logic [2:0] op, input logic [3:0] pos,
                               input logic [7:0] val, input logic first_char,
                               input logic final_char, input bit drain = 1'b0);
        op_request_t r;
        r.op         = op;
        r.pos        = pos;
        r.val        = val;
        r.first_char = first_char;
        r.final_char = final_char;
        r.drain      = drain;
        op_requests.push_back(r);
        requests_total++;
    endtask

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 5))
            0: return 8'h30 + 8'($urandom_range(0, 9));
            1: return 8'h61 + 8'($urandom_range(0, 5));
            2: return 8'h41 + 8'($urandom_range(0, 5));
            3: return CHAR_DOT;
            4: return CHAR_DASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [3:0] rnd4();
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rnd1();
        return 1'($urandom_range(0, 1));
    endfunction

    // Drive requests at the falling edge; hold each until it is taken
    always @(negedge aclk) begin
        op_request_t r;
        if ($urandom_range(0, 49) == 0) begin
            sender_idling <= ~sender_idling;
        end
        if (aresetn && (req_taken || !s_tvalid)) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (op_requests.size() == 0 ||
                         (op_requests[0].drain && expected_frames.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                r = op_requests.pop_front();
                s_tdata  <= {1'b0, r.val, r.pos, r.op};
                s_tuser  <= r.first_char;
                s_tlast  <= r.final_char;
                s_tvalid <= 1'b1;
                if (op_requests.size() > TAIL_ITEMS && sender_idling &&
                    $urandom_range(0, 4) == 0) begin
                    send_gap <= $urandom_range(1, 14);
                end
            end
        end
    end

    // Stall the result side in bursts
    always @(negedge aclk) begin
        if ($urandom_range(0, 49) == 0) begin
            sink_idling <= ~sink_idling;
        end
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (op_requests.size() > TAIL_ITEMS && sink_idling &&
                     $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check results, predict from accepted requests, watch for a hang
    always @(posedge aclk) begin
        frame_t      want;
        op_request_t got;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected frame_byte %02h", m_tdata);
                    error_count++;
                end else begin
                    want = expected_frames.pop_front();
                    if (m_tdata !== want.code) begin
                        $error("frame_byte expected %02h actual %02h", want.code, m_tdata);
                        error_count++;
                    end
                    if (m_tuser[0] !== want.opens) begin
                        $error("frame_start expected %0b actual %0b", want.opens, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tuser[1] !== want.closes) begin
                        $error("frame_end expected %0b actual %0b", want.closes, m_tuser[1]);
                        error_count++;
                    end
                    if (m_tlast !== want.tail) begin
                        $error("last expected %0b actual %0b", want.tail, m_tlast);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                got.op         = s_tdata[2:0];
                got.pos        = s_tdata[6:3];
                got.val        = s_tdata[14:7];
                got.first_char = s_tuser;
                got.final_char = s_tlast;
                got.drain      = 1'b0;
                frame_operation(got);
                requests_taken++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial begin
        int len;
        int r;
        logic [7:0] dir_chars [8];

        // Directed: every operation, field extremes, cursor wrap, dot handling
        dir_chars = '{8'h30, 8'h39, 8'h61, 8'h66, 8'h41, 8'h46, CHAR_DASH, 8'h47};
        add_request(OP_INIT, 4'h0, 8'h00, 1'b0, 1'b0);
        add_request(OP_BRIGHTNESS, 4'hF, 8'hF0, 1'b1, 1'b1);
        add_request(OP_BRIGHTNESS, 4'h0, 8'h0F, 1'b0, 1'b0);
        add_request(OP_SET_LED, 4'h0, 8'hFF, 1'b0, 1'b1);
        add_request(OP_SET_LED, 4'h8, 8'h00, 1'b1, 1'b0);
        add_request(OP_SET_LED, 4'hF, 8'hA5, 1'b0, 1'b0);
        add_request(OP_RAW_WRITE, 4'h0, 8'h00, 1'b0, 1'b0);
        add_request(OP_RAW_WRITE, 4'hF, 8'hFF, 1'b1, 1'b1);
        // eight characters walk the cursor once around the display
        for (int i = 0; i < 8; i++) begin
            add_request(OP_WRITE_CHAR, rnd4(), dir_chars[i], 1'b0, 1'b0);
        end
        // leading dot, dot after a glyph, repeated dot
        add_request(OP_STRING, 4'h0, CHAR_DOT, 1'b1, 1'b0);
        add_request(OP_STRING, 4'h0, CHAR_DOT, 1'b0, 1'b0);
        add_request(OP_STRING, 4'h0, CHAR_DOT, 1'b0, 1'b0);
        add_request(OP_STRING, 4'h0, 8'h31, 1'b0, 1'b0);
        // new string drops the glyph still held; dot closes it
        add_request(OP_STRING, 4'h0, 8'h32, 1'b1, 1'b0);
        add_request(OP_STRING, 4'h0, CHAR_DOT, 1'b0, 1'b1);
        add_request(OP_STRING, 4'h0, 8'h37, 1'b1, 1'b1);
        add_request(OP_UNDEFINED, 4'hF, 8'hFF, 1'b1, 1'b1);
        add_request(OP_CLEAR, 4'h0, 8'h00, 1'b0, 1'b0);

        // Random: mostly well-formed strings, mixed with the other operations
        r = 0;
        while (requests_total < 120) begin
            r = $urandom_range(0, 15);
            if (r <= 5) begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    add_request(OP_STRING, rnd4(), random_char(), i == 0, i == len - 1);
                end
            end else if (r == 6) begin
                add_request(OP_SET_LED, rnd4(), rnd8(), rnd1(), rnd1());
            end else if (r == 7) begin
                add_request(OP_RAW_WRITE, rnd4(), rnd8(), rnd1(), rnd1());
            end else if (r <= 9) begin
                add_request(OP_WRITE_CHAR, rnd4(), random_char(), rnd1(), rnd1());
            end else if (r == 10) begin
                add_request(OP_BRIGHTNESS, rnd4(), rnd8(), rnd1(), rnd1());
            end else if (r == 11) begin
                add_request($urandom_range(0, 2) == 0 ? OP_INIT : OP_CLEAR,
                            rnd4(), rnd8(), rnd1(), rnd1());
            end else if (r == 12) begin
                add_request(OP_UNDEFINED, rnd4(), rnd8(), rnd1(), rnd1());
            end else begin
                add_request(OP_STRING, rnd4(), random_char(), rnd1(), rnd1());
            end
        end
        // hold the sender until all directed bytes are out
        op_requests[25].drain = 1'b1;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait until every request is taken and every byte has come back
        while (requests_taken < requests_total || expected_frames.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
